// File: rtl/encoder_set_daily_time_switch_assert.svh
// Assertion macros shared by the daily time switch RTL.
`ifndef ENCODER_SET_DAILY_TIME_SWITCH_ASSERT_SVH
`define ENCODER_SET_DAILY_TIME_SWITCH_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define EDTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define EDTS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: rtl/edts_pkg.sv
// Types and constants for the encoder-set daily time switch.
package edts_pkg;

  localparam int unsigned InW     = 16;
  localparam int unsigned OutW    = 40;
  localparam int unsigned DebW    = 10;
  localparam int unsigned SaveW   = 14;
  localparam int unsigned CfgDW   = 14;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned MinW    = 11;

  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE   = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_SAVE_DELAY = 1'd1;

  localparam logic [DebW-1:0]  DEBOUNCE_RST   = 10'd500;
  localparam logic [SaveW-1:0] SAVE_DELAY_RST = 14'd5000;
  localparam logic [DebW-1:0]  PRESS_CNT_MAX  = 10'd1023;
  localparam logic [SaveW-1:0] CHANGE_CNT_MAX = 14'd16383;

  localparam logic [7:0] HOUR_MAX   = 8'd23;
  localparam logic [7:0] MINUTE_MAX = 8'd59;
  localparam logic [7:0] POS_MAX    = 8'd255;
  localparam logic [MinW-1:0] DAY_MINUTES = 11'd1440;

  // Edit menu entries
  localparam logic [2:0] MENU_NONE     = 3'd0;
  localparam logic [2:0] MENU_ON_HR    = 3'd1;
  localparam logic [2:0] MENU_ON_MIN   = 3'd2;
  localparam logic [2:0] MENU_OFF_HR   = 3'd3;
  localparam logic [2:0] MENU_OFF_MIN  = 3'd4;
  localparam logic [2:0] MENU_CLK_HR   = 3'd5;
  localparam logic [2:0] MENU_CLK_MIN  = 3'd6;

  typedef enum logic [1:0] {
    WR_NONE    = 2'd0,
    WR_HOURS   = 2'd1,
    WR_MINUTES = 2'd2
  } wr_kind_e;

  typedef struct packed {
    logic       save_pulse;
    logic [5:0] clock_write_value;
    logic [5:0] off_minutes_value;
    logic [4:0] off_hours_value;
    logic [5:0] on_minutes_value;
    logic [4:0] on_hours_value;
    logic [2:0] selected_item;
    logic       light_on;
  } result_t;

  typedef struct packed {
    result_t  data;
    wr_kind_e kind;
  } out_item_t;

  // Minutes of the day for an hour/minute pair: h*60 + m.
  function automatic logic [MinW-1:0] day_minutes(input logic [4:0] h, input logic [5:0] m);
    logic [MinW-1:0] hx;
    hx = MinW'(h);
    return (hx << 6) - (hx << 2) + MinW'(m);
  endfunction

endpackage

// File: rtl/encoder_set_daily_time_switch.sv
// Daily time switch: encoder and button edit the on/off times and clock.
//
// Slave stream carries one pin sample per request (encoder A/B, button,
// millisecond tick, current clock time); the master stream returns one
// result per request: lamp enable, menu entry, stored switch times, a clock
// write request and the save pulse.
// Each request is handled in the cycle it is accepted; its result goes
// to the output register, or to the skid stage if one already waits:
// 1 request per cycle while s_axis_tready is high. The output register
// is backed by a one-entry skid stage, so a request is still taken while
// one result waits; s_axis_tready drops only when both hold results.
// Reset clears the switch times, menu, encoder position and counters, and
// loads debounce 500 ms and save delay 5000 ms. Write cfg_wdata_i to register
// cfg_idx_i (0 debounce, 1 save delay) while the block is idle.
// When the receiver stalls, results stay in order and nothing is dropped.
module encoder_set_daily_time_switch (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [edts_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [edts_pkg::CfgDW-1:0]   cfg_wdata_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // enc_a, enc_b, button_n, ms_tick, clock_hours[4:0], clock_minutes[5:0], pad
  input  logic [edts_pkg::InW-1:0]     s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // light_on, selected_item[2:0], on_hours_value[4:0], on_minutes_value[5:0],
  // off_hours_value[4:0], off_minutes_value[5:0], clock_write_value[5:0],
  // save_pulse, pad
  output logic [edts_pkg::OutW-1:0]    m_axis_tdata,
  // clock_write_kind[1:0]
  output logic [1:0]                   m_axis_tuser
);
  import edts_pkg::*;

  `include "encoder_set_daily_time_switch_assert.svh"

  // Configuration
  logic [DebW-1:0]  debounce_q;
  logic [SaveW-1:0] save_delay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= DEBOUNCE_RST;
      save_delay_q <= SAVE_DELAY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEBOUNCE:   debounce_q   <= cfg_wdata_i[DebW-1:0];
        CFG_SAVE_DELAY: save_delay_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Switch state
  logic             prev_a_q, prev_b_q, a_armed_q, b_armed_q;
  logic [7:0]       pos_q, last_pos_q;
  logic [2:0]       menu_q;
  logic [4:0]       on_hr_q, off_hr_q;
  logic [5:0]       on_min_q, off_min_q;
  logic             prev_btn_q, save_pend_q;
  logic [DebW-1:0]  since_press_q;
  logic [SaveW-1:0] since_change_q;

  logic             a_armed_d, b_armed_d, save_pend_d;
  logic [7:0]       pos_d, last_pos_d;
  logic [2:0]       menu_d;
  logic [4:0]       on_hr_d, off_hr_d;
  logic [5:0]       on_min_d, off_min_d;
  logic [DebW-1:0]  since_press_d;
  logic [SaveW-1:0] since_change_d;
  out_item_t        res;

  logic       in_a, in_b, in_btn, in_tick;
  logic [4:0] in_hr;
  logic [5:0] in_min;
  logic       push, pop;

  assign in_a    = s_axis_tdata[0];
  assign in_b    = s_axis_tdata[1];
  assign in_btn  = s_axis_tdata[2];
  assign in_tick = s_axis_tdata[3];
  assign in_hr   = s_axis_tdata[8:4];
  assign in_min  = s_axis_tdata[14:9];

  logic [MinW-1:0] t_start, t_end, t_now, t_now_r, t_dur, t_elapsed;
  logic            press;
  logic [7:0]      clamped;

  always_comb begin
    a_armed_d      = a_armed_q;
    b_armed_d      = b_armed_q;
    pos_d          = pos_q;
    last_pos_d     = last_pos_q;
    menu_d         = menu_q;
    on_hr_d        = on_hr_q;
    on_min_d       = on_min_q;
    off_hr_d       = off_hr_q;
    off_min_d      = off_min_q;
    save_pend_d    = save_pend_q;
    since_press_d  = since_press_q;
    since_change_d = since_change_q;
    res            = '0;
    res.kind       = WR_NONE;
    clamped        = '0;

    // Advance the millisecond counters, holding at their maximum
    if (in_tick) begin
      if (since_press_q != PRESS_CNT_MAX) since_press_d = since_press_q + 1'b1;
      if (since_change_q != CHANGE_CNT_MAX) since_change_d = since_change_q + 1'b1;
    end

    // Quadrature: A rising edge steps down, B rising edge steps up
    if (in_a && !prev_a_q) begin
      if (in_b && a_armed_d) begin
        if (pos_d != 8'd0) pos_d = pos_d - 1'b1;
        a_armed_d = 1'b0;
        b_armed_d = 1'b0;
      end else if (!in_b) begin
        b_armed_d = 1'b1;
      end
    end
    if (in_b && !prev_b_q) begin
      if (in_a && b_armed_d) begin
        if (pos_d != POS_MAX) pos_d = pos_d + 1'b1;
        a_armed_d = 1'b0;
        b_armed_d = 1'b0;
      end else if (!in_a) begin
        a_armed_d = 1'b1;
      end
    end

    // Debounced press: step the menu and load the selected setting
    press = prev_btn_q && !in_btn &&
            ((since_press_d > debounce_q) || (since_press_d == PRESS_CNT_MAX));
    if (press) begin
      since_press_d = '0;
      menu_d = (menu_q < MENU_CLK_MIN) ? menu_q + 1'b1 : MENU_NONE;
      unique case (menu_d)
        MENU_ON_HR:   pos_d = 8'(on_hr_q);
        MENU_ON_MIN:  pos_d = 8'(on_min_q);
        MENU_OFF_HR:  pos_d = 8'(off_hr_q);
        MENU_OFF_MIN: pos_d = 8'(off_min_q);
        MENU_CLK_HR:  pos_d = 8'(in_hr);
        MENU_CLK_MIN: pos_d = 8'(in_min);
        default: ;
      endcase
      last_pos_d = pos_d;
    end

    // Write a moved position to the selected setting
    if (pos_d != last_pos_d) begin
      unique case (menu_d)
        MENU_ON_HR, MENU_OFF_HR, MENU_CLK_HR:
          clamped = (pos_d > HOUR_MAX) ? HOUR_MAX : pos_d;
        MENU_ON_MIN, MENU_OFF_MIN, MENU_CLK_MIN:
          clamped = (pos_d > MINUTE_MAX) ? MINUTE_MAX : pos_d;
        default: clamped = pos_d;
      endcase
      pos_d = clamped;
      unique case (menu_d)
        MENU_ON_HR:   on_hr_d   = clamped[4:0];
        MENU_ON_MIN:  on_min_d  = clamped[5:0];
        MENU_OFF_HR:  off_hr_d  = clamped[4:0];
        MENU_OFF_MIN: off_min_d = clamped[5:0];
        MENU_CLK_HR: begin
          res.kind = WR_HOURS;
          res.data.clock_write_value = clamped[5:0];
        end
        MENU_CLK_MIN: begin
          res.kind = WR_MINUTES;
          res.data.clock_write_value = clamped[5:0];
        end
        default: ;
      endcase
      if (menu_d >= MENU_ON_HR && menu_d <= MENU_OFF_MIN) begin
        save_pend_d    = 1'b1;
        since_change_d = '0;
      end
      last_pos_d = clamped;
    end

    // Save after the quiet period
    if (save_pend_d &&
        ((since_change_d > save_delay_q) || (since_change_d == CHANGE_CNT_MAX))) begin
      res.data.save_pulse = 1'b1;
      save_pend_d = 1'b0;
    end

    // Lamp: on while now lies in the wrapped interval [start, end)
    t_start   = day_minutes(on_hr_d, on_min_d);
    t_end     = day_minutes(off_hr_d, off_min_d);
    t_now     = day_minutes(in_hr, in_min);
    t_now_r   = (t_now >= DAY_MINUTES) ? t_now - DAY_MINUTES : t_now;
    t_dur     = (t_end >= t_start) ? t_end - t_start : t_end + DAY_MINUTES - t_start;
    t_elapsed = (t_now_r >= t_start) ? t_now_r - t_start
                                     : t_now_r + DAY_MINUTES - t_start;

    res.data.light_on          = (t_elapsed < t_dur);
    res.data.selected_item     = menu_d;
    res.data.on_hours_value    = on_hr_d;
    res.data.on_minutes_value  = on_min_d;
    res.data.off_hours_value   = off_hr_d;
    res.data.off_minutes_value = off_min_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_a_q       <= 1'b1;
      prev_b_q       <= 1'b1;
      a_armed_q      <= 1'b0;
      b_armed_q      <= 1'b0;
      pos_q          <= '0;
      last_pos_q     <= '0;
      menu_q         <= MENU_NONE;
      on_hr_q        <= '0;
      on_min_q       <= '0;
      off_hr_q       <= '0;
      off_min_q      <= '0;
      prev_btn_q     <= 1'b1;
      since_press_q  <= '0;
      save_pend_q    <= 1'b0;
      since_change_q <= '0;
    end else if (push) begin
      prev_a_q       <= in_a;
      prev_b_q       <= in_b;
      a_armed_q      <= a_armed_d;
      b_armed_q      <= b_armed_d;
      pos_q          <= pos_d;
      last_pos_q     <= last_pos_d;
      menu_q         <= menu_d;
      on_hr_q        <= on_hr_d;
      on_min_q       <= on_min_d;
      off_hr_q       <= off_hr_d;
      off_min_q      <= off_min_d;
      prev_btn_q     <= in_btn;
      since_press_q  <= since_press_d;
      save_pend_q    <= save_pend_d;
      since_change_q <= since_change_d;
    end
  end

  // Output register with a one-entry skid stage
  logic      out_valid_q, skid_valid_q;
  out_item_t out_q, skid_q;

  assign s_axis_tready = !skid_valid_q;
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = out_valid_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) skid_valid_q <= 1'b0;
    end else if (push) begin
      if (out_valid_q && !pop) skid_valid_q <= 1'b1;
      else out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) out_q <= skid_q;
    end else if (push) begin
      if (out_valid_q && !pop) skid_q <= res;
      else out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutW - $bits(result_t))'(0), out_q.data};
  assign m_axis_tuser  = out_q.kind;

  `EDTS_ASSERT(a_skid_needs_out, skid_valid_q |-> out_valid_q, "skid full with output empty")
  `EDTS_ASSERT(a_menu_range, menu_q <= MENU_CLK_MIN, "menu entry out of range")
  `EDTS_ASSERT(a_clk_write_menu,
               (push && res.kind != WR_NONE) |-> (menu_d == MENU_CLK_HR || menu_d == MENU_CLK_MIN),
               "clock write outside clock menu entries")
  `EDTS_ASSERT(a_save_pending, (push && res.data.save_pulse) |=> !save_pend_q,
               "save still pending after pulse")
  `EDTS_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> (!out_valid_q && !skid_valid_q),
                      "result held during reset")

endmodule
